>>> rtl/sfcf_pkg.sv
package sfcf_pkg;

   localparam logic [31:0] HDR_SKIP   = 32'h0564_0564;
   localparam logic [31:0] HDR_STABLE = 32'h0565_0565;
   localparam logic [7:0]  CMD_RECORD = 8'h99;
   localparam logic [7:0]  PORT_CODE_FIRST = 8'hE1;
   localparam logic [7:0]  PORT_CODE_LAST  = 8'hE8;
   localparam logic [18:0] POS_MAX = 19'h7FFFF;
   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
   localparam logic [15:0] REFRESH_RESET = 16'd1800;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_LENGTHS       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_ADDRESSES     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_INDEX_OFFSETS = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH_PERIOD     = 8'd3;

   typedef enum logic [2:0] {
      VERDICT_CHANGED   = 3'd0,
      VERDICT_REFRESH   = 3'd1,
      VERDICT_RECORD    = 3'd2,
      VERDICT_UNCHANGED = 3'd3,
      VERDICT_LENGTH    = 3'd4,
      VERDICT_ADDRESS   = 3'd5,
      VERDICT_INDEX     = 3'd6
   } verdict_type;

   typedef enum logic [1:0] {
      KIND_HUNT,
      KIND_SKIP,
      KIND_STABLE
   } frame_kind_type;

   typedef enum logic [2:0] {
      J_CLEAR,
      J_IDLE,
      J_EVAL,
      J_SWEEP,
      J_FINISH,
      J_DONE
   } judge_state_type;

   typedef struct packed {
      logic [63:0] port_lengths;
      logic [63:0] port_addresses;
      logic [63:0] port_index_offsets;
      logic [15:0] refresh_period;
   } cfg_type;

   typedef struct packed {
      logic [15:0] words;
      logic [31:0] header;
      logic [7:0]  index_byte;
   } frame_info_type;

   function automatic logic [2:0] decode_port(logic [7:0] code, int ports);
      logic [7:0] rel;
      rel = code - PORT_CODE_FIRST;
      if (code >= PORT_CODE_FIRST && code <= PORT_CODE_LAST && int'(rel) < ports)
         return rel[2:0];
      return 3'd0;
   endfunction

   function automatic logic [7:0] cfg_byte(logic [63:0] reg_value, logic [2:0] port);
      return reg_value[{port, 3'b000} +: 8];
   endfunction

endpackage

>>> rtl/sfcf_ifs.sv
interface sfcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source(output valid, output data_byte, input ready);
   modport sink(input valid, input data_byte, output ready);
endinterface

interface sfcf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [2:0]  port;
   logic [3:0]  entry_index;
   logic [15:0] packet_words;
   modport source(output valid, output verdict, output port, output entry_index,
                  output packet_words, input ready);
   modport sink(input valid, input verdict, input port, input entry_index,
                input packet_words, output ready);
endinterface

interface sfcf_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/stable_frame_change_filter.sv
// After the last byte of a stable frame the judge checks the header in EVAL and
// goes to DONE, or through SWEEP (payload compare) and FINISH to DONE; DONE holds
// the result until the previous one is taken. Throughput: one byte per cycle while
// the judge is idle, held by the single read port of the payload store during the
// compare (one byte per cycle). Reset: synchronous; afterwards a clearing pass over
// the PORTS * INDEXES * PAYLOAD_BYTES bytes zeroes the store before bytes are taken.
module stable_frame_change_filter
   import sfcf_pkg::*;
#(
   parameter int PORTS = 8,
   parameter int INDEXES = 16,
   parameter int PAYLOAD_BYTES = 48
) (
   input  logic        clock,
   input  logic        reset,
   sfcf_req_if.sink    req_chan,
   sfcf_rsp_if.source  rsp_chan,
   sfcf_csr_if.sink    csr_chan
);

   localparam int CAP_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   cfg_type cfg_ff, cfg_in;
   logic             judge_idle;
   logic             cap_we;
   logic [CAP_W-1:0] cap_addr;
   logic [7:0]       cap_wdata;
   logic             frame_start;
   frame_info_type   frame;
   logic [2:0]       hdr_port;

   assign csr_chan.ready = 1'b1;
   assign hdr_port = decode_port(frame.header[7:0], PORTS);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PORT_LENGTHS:       cfg_in.port_lengths = csr_chan.data;
            CSR_PORT_ADDRESSES:     cfg_in.port_addresses = csr_chan.data;
            CSR_PORT_INDEX_OFFSETS: cfg_in.port_index_offsets = csr_chan.data;
            CSR_REFRESH_PERIOD:     cfg_in.refresh_period = csr_chan.data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{port_lengths: '0, port_addresses: '0, port_index_offsets: '0,
                     refresh_period: REFRESH_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfcf_framer #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .CAP_W(CAP_W)
   ) u_framer (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .judge_idle(judge_idle),
      .cfg(cfg_ff),
      .hdr_port(hdr_port),
      .cap_we(cap_we),
      .cap_addr(cap_addr),
      .cap_wdata(cap_wdata),
      .frame_start(frame_start),
      .frame(frame)
   );

   sfcf_judge #(
      .PORTS(PORTS),
      .INDEXES(INDEXES),
      .PAYLOAD_BYTES(PAYLOAD_BYTES),
      .CAP_W(CAP_W)
   ) u_judge (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .frame_start(frame_start),
      .frame(frame),
      .cap_we(cap_we),
      .cap_addr(cap_addr),
      .cap_wdata(cap_wdata),
      .judge_idle(judge_idle),
      .rsp(rsp_chan)
   );

endmodule

>>> rtl/sfcf_framer.sv
module sfcf_framer
   import sfcf_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 48,
   parameter int CAP_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   sfcf_req_if.sink           req,
   input  logic               judge_idle,
   input  cfg_type            cfg,
   input  logic [2:0]         hdr_port,
   output logic               cap_we,
   output logic [CAP_W-1:0]   cap_addr,
   output logic [7:0]         cap_wdata,
   output logic               frame_start,
   output frame_info_type     frame
);

   frame_kind_type kind_ff, kind_in;
   logic [18:0] pos_ff, pos_in;
   logic [31:0] window_ff, window_in;
   logic [15:0] words_ff, words_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [7:0]  idx_ff, idx_in;

   logic        accept;
   logic [7:0]  b;
   logic [31:0] window_cat;
   logic        hit_skip, hit_stable;
   logic [18:0] rel;
   logic [7:0]  off;
   logic [17:0] span;
   logic [19:0] pos_next;

   assign req.ready = judge_idle;
   assign accept = req.valid && req.ready;
   assign b = req.data_byte;
   assign window_cat = {window_ff[23:0], b};
   assign hit_skip = (window_cat == HDR_SKIP);
   assign hit_stable = (window_cat == HDR_STABLE);
   assign rel = pos_ff - 19'd24;
   assign off = cfg_byte(cfg.port_index_offsets, hdr_port);
   assign cap_wdata = b;
   assign frame = '{words: words_in, header: hdr_in, index_byte: idx_in};

   always_comb begin
      kind_in = kind_ff;
      pos_in = pos_ff;
      window_in = window_ff;
      words_in = words_ff;
      hdr_in = hdr_ff;
      idx_in = idx_ff;
      cap_we = 1'b0;
      cap_addr = rel[CAP_W-1:0];
      frame_start = 1'b0;
      span = '0;
      pos_next = '0;
      if (accept) begin
         if (kind_ff == KIND_HUNT) begin
            window_in = window_cat;
            if (hit_skip || hit_stable) begin
               kind_in = hit_skip ? KIND_SKIP : KIND_STABLE;
               pos_in = 19'd4;
               words_in = '0;
               hdr_in = '0;
               idx_in = '0;
               window_in = '0;
            end
         end else begin
            window_in = window_cat;
            if (pos_ff >= 19'd4 && pos_ff <= 19'd7) begin
               words_in = {words_ff[7:0], b};
            end else if (pos_ff == 19'd8) begin
               hdr_in[7:0] = b;
            end else if (pos_ff == 19'd9) begin
               hdr_in[15:8] = b;
            end
            if (pos_ff == 19'd24) begin
               hdr_in[31:24] = b;
            end else if (pos_ff == 19'd25) begin
               hdr_in[23:16] = b;
            end
            if (pos_ff >= 19'd24 && 32'(rel) < PAYLOAD_BYTES) begin
               cap_we = 1'b1;
            end
            if (off != 8'd0 && pos_ff == 19'd24 + 19'(off)) begin
               idx_in = b;
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 19'd1;
            end
            span = {words_in, 2'b00} + 18'd4;
            pos_next = 20'(pos_ff) + 20'd1;
            if (pos_ff >= 19'd7 && pos_next >= 20'(span)) begin
               frame_start = (kind_ff == KIND_STABLE);
               kind_in = KIND_HUNT;
               pos_in = '0;
               if (words_in == 16'd0) begin
                  if (hit_skip || hit_stable) begin
                     kind_in = hit_skip ? KIND_SKIP : KIND_STABLE;
                     pos_in = 19'd4;
                     words_in = '0;
                     hdr_in = '0;
                     idx_in = '0;
                     window_in = '0;
                  end
               end else begin
                  window_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_HUNT;
         pos_ff <= '0;
         window_ff <= '0;
         words_ff <= '0;
         hdr_ff <= '0;
         idx_ff <= '0;
      end else begin
         kind_ff <= kind_in;
         pos_ff <= pos_in;
         window_ff <= window_in;
         words_ff <= words_in;
         hdr_ff <= hdr_in;
         idx_ff <= idx_in;
      end
   end

endmodule

>>> rtl/sfcf_judge.sv
module sfcf_judge
   import sfcf_pkg::*;
#(
   parameter int PORTS = 8,
   parameter int INDEXES = 16,
   parameter int PAYLOAD_BYTES = 48,
   parameter int CAP_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               frame_start,
   input  frame_info_type     frame,
   input  logic               cap_we,
   input  logic [CAP_W-1:0]   cap_addr,
   input  logic [7:0]         cap_wdata,
   output logic               judge_idle,
   sfcf_rsp_if.source         rsp
);

   localparam int SLOTS = PORTS * INDEXES;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DEPTH = SLOTS * PAYLOAD_BYTES;
   localparam int ST_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] store_mem [DEPTH];
   logic [7:0] cap_mem [PAYLOAD_BYTES];
   logic [7:0] store_rdata_ff, cap_rdata_ff;
   logic       store_we;
   logic [ST_W-1:0] store_waddr, store_raddr;
   logic [7:0] store_wdata;
   logic [CAP_W-1:0] cap_raddr;

   judge_state_type state_ff, state_in;
   frame_info_type  info_ff, info_in;
   logic [ST_W-1:0] clr_ff, clr_in;
   logic [SLOTS-1:0] marks_ff, marks_in;
   logic [16:0] counted_ff, counted_in;
   verdict_type verdict_ff, verdict_in;
   logic [2:0]  port_ff, port_in;
   logic [7:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ST_W-1:0] base_ff, base_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  rd_cnt_ff, rd_cnt_in;
   logic        pend_ff, pend_in;
   logic [ST_W-1:0] wr_addr_ff, wr_addr_in;
   logic        differ_ff, differ_in;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [2:0]  rsp_port_ff, rsp_port_in;
   logic [3:0]  rsp_idx_ff, rsp_idx_in;
   logic [15:0] rsp_words_ff, rsp_words_in;

   logic [2:0]  e_port;
   logic [7:0]  e_len, e_cmd, e_addr, e_off;
   logic [17:0] e_span;
   logic        e_over;
   logic [16:0] e_cnt;
   logic        e_short;
   logic [SLOT_W-1:0] e_slot;

   assign judge_idle = (state_ff == J_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.verdict = rsp_verdict_ff;
   assign rsp.port = rsp_port_ff;
   assign rsp.entry_index = rsp_idx_ff;
   assign rsp.packet_words = rsp_words_ff;

   assign store_raddr = base_ff + ST_W'(rd_cnt_ff);
   assign cap_raddr = rd_cnt_ff[CAP_W-1:0];

   assign e_port = decode_port(info_ff.header[7:0], PORTS);
   assign e_len = info_ff.header[15:8];
   assign e_cmd = info_ff.header[23:16];
   assign e_addr = info_ff.header[31:24];
   assign e_off = cfg_byte(cfg.port_index_offsets, e_port);
   assign e_span = {info_ff.words, 2'b00} + 18'd4;
   assign e_over = (counted_ff > {1'b0, cfg.refresh_period});
   assign e_cnt = e_over ? 17'd0 : counted_ff;
   assign e_short = (e_span < 18'd26) || (e_span < 18'd24 + 18'(e_len));
   assign e_slot = SLOT_W'(32'(e_port) * INDEXES + 32'(idx_in));

   always_comb begin
      state_in = state_ff;
      info_in = info_ff;
      clr_in = clr_ff;
      marks_in = marks_ff;
      counted_in = counted_ff;
      verdict_in = verdict_ff;
      port_in = port_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      base_in = base_ff;
      len_in = len_ff;
      rd_cnt_in = rd_cnt_ff;
      pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      differ_in = differ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_port_in = rsp_port_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_words_in = rsp_words_ff;
      store_we = 1'b0;
      store_waddr = wr_addr_ff;
      store_wdata = cap_rdata_ff;
      case (state_ff)
         J_CLEAR: begin
            store_we = 1'b1;
            store_waddr = clr_ff;
            store_wdata = 8'd0;
            clr_in = clr_ff + ST_W'(1);
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = J_IDLE;
            end
         end
         J_IDLE: begin
            if (frame_start) begin
               info_in = frame;
               state_in = J_EVAL;
            end
         end
         J_EVAL: begin
            if (e_over) begin
               marks_in = '1;
            end
            counted_in = e_cnt;
            port_in = e_port;
            idx_in = 8'd0;
            len_in = e_len;
            state_in = J_DONE;
            if (e_short) begin
               port_in = (e_span < 18'd12) ? 3'd0 : e_port;
               verdict_in = VERDICT_LENGTH;
            end else if (e_cmd == CMD_RECORD) begin
               verdict_in = VERDICT_RECORD;
               if (e_cnt != COUNT_MAX) begin
                  counted_in = e_cnt + 17'd1;
               end
            end else if (e_len != cfg_byte(cfg.port_lengths, e_port) ||
                         32'(e_len) > PAYLOAD_BYTES) begin
               verdict_in = VERDICT_LENGTH;
            end else if (e_addr != cfg_byte(cfg.port_addresses, e_port)) begin
               verdict_in = VERDICT_ADDRESS;
            end else if (e_off != 8'd0 && e_off >= e_len) begin
               verdict_in = VERDICT_INDEX;
            end else begin
               if (e_off != 8'd0) begin
                  idx_in = info_ff.index_byte;
               end
               if (e_off != 8'd0 && 32'(info_ff.index_byte) >= INDEXES) begin
                  verdict_in = VERDICT_INDEX;
               end else begin
                  slot_in = e_slot;
                  base_in = ST_W'(32'(e_slot) * PAYLOAD_BYTES);
                  rd_cnt_in = 8'd0;
                  differ_in = 1'b0;
                  state_in = J_SWEEP;
               end
            end
         end
         J_SWEEP: begin
            if (pend_ff) begin
               store_we = 1'b1;
               if (store_rdata_ff != cap_rdata_ff) begin
                  differ_in = 1'b1;
               end
            end
            if (rd_cnt_ff < len_ff) begin
               pend_in = 1'b1;
               wr_addr_in = store_raddr;
               rd_cnt_in = rd_cnt_ff + 8'd1;
            end else if (!pend_ff) begin
               state_in = J_FINISH;
            end
         end
         J_FINISH: begin
            if (differ_ff) begin
               verdict_in = VERDICT_CHANGED;
            end else if (marks_ff[slot_ff]) begin
               marks_in[slot_ff] = 1'b0;
               verdict_in = VERDICT_REFRESH;
            end else begin
               verdict_in = VERDICT_UNCHANGED;
            end
            if (counted_ff != COUNT_MAX) begin
               counted_in = counted_ff + 17'd1;
            end
            state_in = J_DONE;
         end
         J_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_port_in = port_ff;
               rsp_idx_in = idx_ff[3:0];
               rsp_words_in = info_ff.words;
               state_in = J_IDLE;
            end
         end
         default: begin
            state_in = J_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      store_rdata_ff <= store_mem[store_raddr];
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_addr] <= cap_wdata;
      end
      cap_rdata_ff <= cap_mem[cap_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= J_CLEAR;
         clr_ff <= '0;
         marks_ff <= '0;
         counted_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         marks_ff <= marks_in;
         counted_ff <= counted_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      info_ff <= info_in;
      verdict_ff <= verdict_in;
      port_ff <= port_in;
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      base_ff <= base_in;
      len_ff <= len_in;
      rd_cnt_ff <= rd_cnt_in;
      wr_addr_ff <= wr_addr_in;
      differ_ff <= differ_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_port_ff <= rsp_port_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_words_ff <= rsp_words_in;
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      frame_start |-> state_ff == J_IDLE)
      else $error("frame start while the judge is busy");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == J_SWEEP |-> rd_cnt_ff <= len_ff)
      else $error("payload sweep ran past the frame length");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == J_DONE && (!rsp_valid_ff || rsp.ready) |=> rsp_valid_ff)
      else $error("result not presented after judgement");

   a_pending_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == J_SWEEP)
      else $error("store write-back outside the sweep");

endmodule
